@@ hw/rtl/stsi_pkg.sv @@
// ----------------------------------------------------------------------------
// stsi_pkg
// Types and constants of the sorted time-series interpolation table.
// ----------------------------------------------------------------------------
package stsi_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int TIME_BITS   = 36;
   localparam int IDX_BITS    = $clog2(TABLE_DEPTH);
   localparam int CNT_BITS    = $clog2(TABLE_DEPTH + 1);
   localparam int VAL_BITS    = 32;
   localparam int PROD_BITS   = TIME_BITS + VAL_BITS + 1;
   localparam int PSTEP_BITS  = $clog2(VAL_BITS + 2);
   localparam int DSTEP_BITS  = $clog2(PROD_BITS + 1);

   typedef enum logic [1:0] {
      REQ_INSERT = 2'd0,
      REQ_LOOKUP = 2'd1,
      REQ_INTERP = 2'd2,
      REQ_CLEAR  = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOTFOUND = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SRD,     // issue search read
      S_SCMP,    // compare read word
      S_SHRD,    // shift: read entry below
      S_SHWR,    // shift: write it one up
      S_INS,     // write new point
      S_ILO,     // read lower point
      S_ILOW,    // capture lower point
      S_MUL,     // shift-add multiply
      S_DIV,     // restoring division
      S_DONE,
      S_OUT
   } state_type;

   typedef struct packed {
      logic                 ok;
      logic [VAL_BITS-1:0]  result_value;
      status_type           status;
      logic [CNT_BITS-1:0]  entry_count;
   } rsp_word_type;

endpackage

@@ hw/rtl/stsi_if.sv @@
// ----------------------------------------------------------------------------
// stsi_req_if / stsi_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
interface stsi_req_if import stsi_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [1:0]           req_type;
   logic [TIME_BITS-1:0] sample_time;
   logic [VAL_BITS-1:0]  sample_value;
   modport source (output valid, req_type, sample_time, sample_value, input ready);
   modport sink   (input valid, req_type, sample_time, sample_value, output ready);
endinterface

interface stsi_rsp_if import stsi_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic                 ok;
   logic [VAL_BITS-1:0]  result_value;
   logic [1:0]           status;
   logic [CNT_BITS-1:0]  entry_count;
   modport source (output valid, ok, result_value, status, entry_count, input ready);
   modport sink   (input valid, ok, result_value, status, entry_count, output ready);
endinterface

@@ hw/rtl/stsi_ram.sv @@
// ----------------------------------------------------------------------------
// stsi_ram
// Generic single-port RAM, registered read.
// ----------------------------------------------------------------------------
module stsi_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[addr] <= wdata;
      rdata <= mem[addr];
   end
endmodule

@@ hw/rtl/sorted_time_series_interpolator_unit.sv @@
// ----------------------------------------------------------------------------
// sorted_time_series_interpolator_unit
// Sorted (time, value) table with insert, exact lookup, linear interpolation, clear.
// ----------------------------------------------------------------------------
//  channel | dir | payload
//  req     | in  | req_type, sample_time, sample_value
//  rsp     | out | ok, result_value, status, entry_count
//
//  Work: a linear search visits one entry at a time; insert moves each
//  entry at or above the insert position up by one; interpolation adds 37
//  shift-add multiply and 69 restoring divide steps. Response
//  back-pressure stalls each word in addition.
//  Reset clears the point count and returns the FSM to idle; the RAM is never cleared.
//  req_ready is high only when idle; a held response stalls the next word.
module sorted_time_series_interpolator_unit
   import stsi_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   stsi_req_if.sink    req,
   stsi_rsp_if.source  rsp
);

   state_type            state_ff, state_in;
   logic [1:0]           kind_ff;
   logic [TIME_BITS-1:0] t_ff;
   logic [VAL_BITS-1:0]  v_ff;
   logic [CNT_BITS-1:0]  held_ff, held_in;
   logic [CNT_BITS-1:0]  idx_ff, idx_in;     // search / shift pointer
   logic [CNT_BITS-1:0]  pos_ff, pos_in;     // insert position / upper index
   logic [TIME_BITS-1:0] t1_ff, t1_in;
   logic [VAL_BITS-1:0]  y1_ff, y1_in;
   logic [VAL_BITS-1:0]  y0_ff, y0_in;
   logic [TIME_BITS-1:0] t0_ff, t0_in;
   logic [PROD_BITS-1:0] acc_ff, acc_in;     // product, then quotient
   logic [VAL_BITS:0]    mag_ff, mag_in;
   logic [TIME_BITS:0]   rem_ff, rem_in;
   logic                 neg_ff, neg_in;
   logic [DSTEP_BITS-1:0] step_ff, step_in;
   logic                 wait_ff, wait_in;   // set while a RAM read is pending
   rsp_word_type         out_ff, out_in;

   logic                 we;
   logic [IDX_BITS-1:0]  addr;
   logic [TIME_BITS-1:0] wt, rt;
   logic [VAL_BITS-1:0]  wv, rv;

   stsi_ram #(.WIDTH(TIME_BITS), .DEPTH(TABLE_DEPTH)) u_times (
      .clock(clock), .we(we), .addr(addr), .wdata(wt), .rdata(rt));
   stsi_ram #(.WIDTH(VAL_BITS), .DEPTH(TABLE_DEPTH)) u_vals (
      .clock(clock), .we(we), .addr(addr), .wdata(wv), .rdata(rv));

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = (state_ff == S_OUT);
   assign rsp.ok           = out_ff.ok;
   assign rsp.result_value = out_ff.result_value;
   assign rsp.status       = out_ff.status;
   assign rsp.entry_count  = out_ff.entry_count;

   // adder/subtractor terms of the multiply and divide steps
   logic [PROD_BITS-1:0] mul_sum;
   logic [TIME_BITS+1:0] trial;
   logic [TIME_BITS:0]   rsh;
   logic [TIME_BITS-1:0] x1;
   assign mul_sum = acc_ff + (PROD_BITS'(mag_ff) << TIME_BITS);
   assign x1      = t1_ff - t0_ff;
   assign rsh     = {rem_ff[TIME_BITS-1:0], acc_ff[PROD_BITS-1]};
   assign trial   = {1'b0, rsh} - {2'b0, x1};

   logic [VAL_BITS:0]    dy;
   assign dy = {y1_ff[VAL_BITS-1], y1_ff} - {y0_ff[VAL_BITS-1], y0_ff};

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         held_ff  <= '0;
      end else begin
         state_ff <= state_in;
         held_ff  <= held_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         kind_ff <= req.req_type;
         t_ff    <= req.sample_time;
         v_ff    <= req.sample_value;
      end
      idx_ff <= idx_in;   pos_ff <= pos_in;
      t1_ff  <= t1_in;    y1_ff  <= y1_in;
      t0_ff  <= t0_in;    y0_ff  <= y0_in;
      acc_ff <= acc_in;   mag_ff <= mag_in;
      rem_ff <= rem_in;   neg_ff <= neg_in;
      step_ff <= step_in; wait_ff <= wait_in;
      out_ff <= out_in;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req.valid) begin
               case (req.req_type)
                  REQ_CLEAR: state_in = S_DONE;
                  REQ_INSERT:
                     state_in = (held_ff == CNT_BITS'(TABLE_DEPTH)) ? S_DONE : S_SRD;
                  default: state_in = (held_ff == '0) ? S_DONE : S_SRD;
               endcase
            end
         end
         S_SRD:  state_in = (idx_ff == held_ff) ? S_SCMP : S_SCMP;
         S_SCMP: begin
            if (idx_ff == held_ff) begin
               state_in = (kind_ff == REQ_INSERT) ? S_INS : S_DONE;
            end else if (wait_ff) begin
               state_in = S_SCMP;
            end else if (rt > t_ff) begin
               if (kind_ff == REQ_INSERT)
                  state_in = (held_ff == idx_ff) ? S_INS : S_SHRD;
               else if (kind_ff == REQ_INTERP && idx_ff != '0)
                  state_in = S_ILO;
               else
                  state_in = S_DONE;
            end else if (rt == t_ff && kind_ff != REQ_INSERT) begin
               state_in = S_DONE;
            end else begin
               state_in = S_SRD;
            end
         end
         S_SHRD: state_in = wait_ff ? S_SHRD : S_SHWR;
         S_SHWR: state_in = (idx_ff - 1'b1 == pos_ff) ? S_INS : S_SHRD;
         S_INS:  state_in = S_DONE;
         S_ILO:  state_in = S_ILOW;
         S_ILOW: state_in = wait_ff ? S_ILOW : S_MUL;
         S_MUL:  state_in = (step_ff == DSTEP_BITS'(TIME_BITS)) ? S_DIV : S_MUL;
         S_DIV:  state_in = (step_ff == DSTEP_BITS'(PROD_BITS - 1)) ? S_DONE : S_DIV;
         S_DONE: state_in = S_OUT;
         S_OUT:  state_in = rsp.ready ? S_IDLE : S_OUT;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath control
   always_comb begin
      held_in = held_ff;
      idx_in = idx_ff;   pos_in = pos_ff;
      t1_in = t1_ff;     y1_in = y1_ff;
      t0_in = t0_ff;     y0_in = y0_ff;
      acc_in = acc_ff;   mag_in = mag_ff;
      rem_in = rem_ff;   neg_in = neg_ff;
      step_in = step_ff; wait_in = 1'b0;
      out_in = out_ff;
      we = 1'b0;
      addr = idx_ff[IDX_BITS-1:0];
      wt = t1_ff;
      wv = y1_ff;
      case (state_ff)
         S_IDLE: begin
            idx_in = '0;
            out_in = '{ok: 1'b0, result_value: '0, status: ST_OK, entry_count: held_ff};
            if (req.valid) begin
               case (req.req_type)
                  REQ_CLEAR: begin
                     held_in = '0;
                     out_in = '{ok: 1'b1, result_value: '0, status: ST_OK, entry_count: '0};
                  end
                  REQ_INSERT:
                     if (held_ff == CNT_BITS'(TABLE_DEPTH)) out_in.status = ST_FULL;
                  default: begin
                     if (held_ff == '0) out_in.status = ST_EMPTY;
                     else out_in.status = ST_NOTFOUND;
                  end
               endcase
            end
         end
         S_SRD: wait_in = 1'b1;
         S_SCMP: begin
            if (idx_ff == held_ff) begin
               pos_in = held_ff;
            end else if (!wait_ff) begin
               if (rt > t_ff) begin
                  pos_in = idx_ff;
                  t1_in  = rt;
                  y1_in  = rv;
                  idx_in = held_ff;
                  if (kind_ff == REQ_INTERP && idx_ff != '0) idx_in = idx_ff - 1'b1;
                  if (kind_ff == REQ_INSERT) wait_in = 1'b1;
               end else if (rt == t_ff && kind_ff != REQ_INSERT) begin
                  out_in.ok = 1'b1;
                  out_in.status = ST_OK;
                  out_in.result_value = rv;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
            if (state_in == S_SHRD) addr = IDX_BITS'(held_ff - 1'b1);
         end
         S_SHRD: begin
            addr = IDX_BITS'(idx_ff - 1'b1);
            t1_in = rt; y1_in = rv;
         end
         S_SHWR: begin
            we = 1'b1;
            wt = rt; wv = rv;
            idx_in = idx_ff - 1'b1;
            wait_in = 1'b1;
            if (idx_ff - 1'b1 != pos_ff) addr = IDX_BITS'(idx_ff);
         end
         S_INS: begin
            we = 1'b1;
            addr = pos_ff[IDX_BITS-1:0];
            wt = t_ff; wv = v_ff;
            held_in = held_ff + 1'b1;
            out_in.ok = 1'b1;
            out_in.status = ST_OK;
            out_in.entry_count = held_ff + 1'b1;
         end
         S_ILO: wait_in = 1'b1;
         S_ILOW: begin
            t0_in = rt; y0_in = rv;
            acc_in = '0; step_in = '0;
         end
         S_MUL: begin
            // first step captures |dy|, then add-and-shift over every bit of x
            if (step_ff == '0) begin
               neg_in = dy[VAL_BITS];
               mag_in = dy[VAL_BITS] ? (~dy + 1'b1) : dy;
               acc_in = PROD_BITS'(t_ff - t0_ff);
               step_in = step_ff + 1'b1;
            end else begin
               acc_in = acc_ff[0] ? (mul_sum >> 1) : (acc_ff >> 1);
               step_in = step_ff + 1'b1;
               if (step_ff == DSTEP_BITS'(TIME_BITS)) begin
                  step_in = '0;
                  rem_in = '0;
                  acc_in = (acc_ff[0] ? (mul_sum >> 1) : (acc_ff >> 1)) >> 0;
               end
            end
         end
         S_DIV: begin
            // one quotient bit per cycle; acc shifts dividend out, quotient in
            step_in = step_ff + 1'b1;
            if (!trial[TIME_BITS+1]) begin
               rem_in = trial[TIME_BITS:0];
               acc_in = {acc_ff[PROD_BITS-2:0], 1'b1};
            end else begin
               rem_in = rsh;
               acc_in = {acc_ff[PROD_BITS-2:0], 1'b0};
            end
         end
         S_DONE: begin
            if (kind_ff == REQ_INTERP && out_in.status == ST_NOTFOUND && !out_ff.ok
                && pos_ff != '0 && pos_ff != held_ff && step_ff != '0) begin
               out_in.ok = 1'b1;
               out_in.status = ST_OK;
               out_in.result_value = neg_ff ? (y0_ff - acc_ff[VAL_BITS-1:0])
                                            : (y0_ff + acc_ff[VAL_BITS-1:0]);
            end
         end
         default: ;
      endcase
   end

   // assertions
   a_rdy_idle: assert property (@(posedge clock) disable iff (reset)
      req.ready |-> !rsp.valid) else $error("ready while response pending");
   a_held_max: assert property (@(posedge clock) disable iff (reset)
      held_ff <= CNT_BITS'(TABLE_DEPTH)) else $error("count overflow");
   a_clear: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready && req.req_type == REQ_CLEAR) |=> held_ff == '0)
      else $error("clear missed");
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.ok) |-> rsp.result_value == '0) else $error("nonzero fail");

endmodule
